// ===== sv/u8m_pkg.sv =====
// Shared types, constants and byte-generation helpers for the UTF-8 converter.
`default_nettype none

package u8m_pkg;

  // Queue between the front and the back end
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Lead byte classes
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] NUL_BYTE   = 8'h00;

  // Encoded null: C0 80
  localparam logic [7:0] NUL_ENC_HI = 8'hC0;
  localparam logic [7:0] NUL_ENC_LO = 8'h80;

  // Surrogate bytes: both units start with ED; high unit mid nibble A, low unit B
  localparam logic [7:0] SURR_LEAD   = 8'hED;
  localparam logic [3:0] SURR_HI_MID = 4'hA;
  localparam logic [3:0] SURR_LO_MID = 4'hB;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  typedef enum logic [1:0] {
    PH_START,
    PH_COPY,
    PH_COLLECT
  } phase_e;

  typedef enum logic [1:0] {
    JOB_BYTE,
    JOB_NULL,
    JOB_SURR,
    JOB_FLUSH
  } job_kind_e;

  // data: BYTE -> [7:0]; SURR -> [19:0] offset; FLUSH -> bytes in arrival order from [7:0]
  typedef struct packed {
    job_kind_e   kind;
    logic [23:0] data;
    logic [1:0]  cnt;
    logic        last;
  } job_t;

  function automatic logic [2:0] job_len(job_t job);
    logic [2:0] len;
    case (job.kind)
      JOB_BYTE:  len = 3'd1;
      JOB_NULL:  len = 3'd2;
      JOB_SURR:  len = 3'd6;
      JOB_FLUSH: len = {1'b0, job.cnt};
      default:   len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] job_byte(job_t job, logic [2:0] idx);
    logic [7:0] b;
    b = job.data[7:0];
    case (job.kind)
      JOB_BYTE: b = job.data[7:0];
      JOB_NULL: b = (idx == 3'd0) ? NUL_ENC_HI : NUL_ENC_LO;
      JOB_SURR: begin
        case (idx)
          3'd0:    b = SURR_LEAD;
          3'd1:    b = {SURR_HI_MID, job.data[19:16]};
          3'd2:    b = {CONT_TAG, job.data[15:10]};
          3'd3:    b = SURR_LEAD;
          3'd4:    b = {SURR_LO_MID, job.data[9:6]};
          3'd5:    b = {CONT_TAG, job.data[5:0]};
          default: b = SURR_LEAD;
        endcase
      end
      JOB_FLUSH: begin
        case (idx)
          3'd0:    b = job.data[7:0];
          3'd1:    b = job.data[15:8];
          3'd2:    b = job.data[23:16];
          default: b = job.data[7:0];
        endcase
      end
      default: b = job.data[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/u8m_in_if.sv =====
// Input channel: one UTF-8 byte per word.
`default_nettype none

interface u8m_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_data;

  modport source (output valid, output in_byte, output end_of_data, input ready);
  modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

`default_nettype wire

// ===== sv/u8m_out_if.sv =====
// Output channel: one modified UTF-8 byte per word.
`default_nettype none

interface u8m_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;

  modport source (output valid, output out_byte, output last_of_run, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input stream_done,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/u8m_front.sv =====
// Front end: tracks sequence state per input byte and issues output jobs.
`default_nettype none

module u8m_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          end_of_data_i,
  output logic               job_valid_o,
  output u8m_pkg::job_t      job_o,
  input  wire logic          job_ready_i
);
  import u8m_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  rem_q, rem_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  coll_q [3];
  logic        coll_we;
  logic [1:0]  coll_wa;
  logic        accept;
  logic        is_lead4, is_lead3, is_lead2;
  logic [19:0] cp;
  logic        job_present;

  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_lead4 = (in_byte_i & LEAD4_MASK) == LEAD4_VAL;
  assign is_lead3 = (in_byte_i & LEAD3_MASK) == LEAD3_VAL;
  assign is_lead2 = (in_byte_i & LEAD2_MASK) == LEAD2_VAL;

  assign cp = {coll_q[0][1:0], coll_q[1][5:0], coll_q[2][5:0], in_byte_i[5:0]};

  // next state
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    coll_we = 1'b0;
    coll_wa = cnt_q;
    case (phase_q)
      PH_COPY: begin
        rem_d = (rem_q != 2'd0) ? rem_q - 2'd1 : 2'd0;
        if (rem_d == 2'd0) begin
          phase_d = PH_START;
        end
      end
      PH_COLLECT: begin
        if (cnt_q == 2'd3) begin
          cnt_d   = 2'd0;
          phase_d = PH_START;
        end else begin
          coll_we = 1'b1;
          coll_wa = cnt_q;
          cnt_d   = cnt_q + 2'd1;
        end
      end
      default: begin
        phase_d = PH_START;
        if (in_byte_i == NUL_BYTE) begin
          phase_d = PH_START;
        end else if (is_lead4) begin
          coll_we = 1'b1;
          coll_wa = 2'd0;
          cnt_d   = 2'd1;
          phase_d = PH_COLLECT;
        end else if (is_lead2) begin
          rem_d   = 2'd1;
          phase_d = PH_COPY;
        end else if (is_lead3) begin
          rem_d   = 2'd2;
          phase_d = PH_COPY;
        end
      end
    endcase
    if (end_of_data_i) begin
      phase_d = PH_START;
      rem_d   = 2'd0;
      cnt_d   = 2'd0;
    end
  end

  // job output
  always_comb begin
    job_present     = 1'b1;
    job_o.kind      = JOB_BYTE;
    job_o.data      = {16'd0, in_byte_i};
    job_o.cnt       = 2'd0;
    job_o.last      = end_of_data_i;
    case (phase_q)
      PH_COPY: begin
        job_o.kind = JOB_BYTE;
      end
      PH_COLLECT: begin
        if (cnt_q == 2'd3) begin
          job_o.kind = JOB_SURR;
          // offset = cp - 0x10000 mod 2^20: only the top nibble moves
          job_o.data = {4'd0, cp[19:16] - 4'd1, cp[15:0]};
        end else if (end_of_data_i) begin
          // cut short: flush what was held plus this byte
          job_o.kind = JOB_FLUSH;
          job_o.cnt  = cnt_q + 2'd1;
          job_o.data = {in_byte_i, (cnt_q == 2'd1) ? in_byte_i : coll_q[1], coll_q[0]};
        end else begin
          job_present = 1'b0;
        end
      end
      default: begin
        if (in_byte_i == NUL_BYTE) begin
          job_o.kind = JOB_NULL;
        end else if (is_lead4) begin
          if (end_of_data_i) begin
            job_o.kind = JOB_FLUSH;
            job_o.cnt  = 2'd1;
          end else begin
            job_present = 1'b0;
          end
        end
      end
    endcase
  end

  assign job_valid_o = in_valid_i && job_present;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      rem_q   <= 2'd0;
      cnt_q   <= 2'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && coll_we) begin
      coll_q[coll_wa] <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/u8m_fifo.sv =====
// Short job queue between the front and the back end.
`default_nettype none

module u8m_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  input  wire u8m_pkg::job_t push_job_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output u8m_pkg::job_t      pop_job_o,
  input  wire logic          pop_ready_i
);
  import u8m_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/u8m_back.sv =====
// Back end: expands each job into bytes, one per unstalled cycle.
`default_nettype none

module u8m_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire u8m_pkg::job_t job_i,
  output logic               job_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o,
  output logic               stream_done_o
);
  import u8m_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic [2:0] len;
  logic       advance, final_byte;
  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       last_q, done_q;

  assign len        = job_len(job_i);
  assign final_byte = idx_q == (len - 3'd1);
  assign advance    = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_ready_o = advance && final_byte;

  always_comb begin
    idx_d = idx_q;
    if (advance) begin
      idx_d = final_byte ? 3'd0 : idx_q + 3'd1;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= job_byte(job_i, idx_q);
      last_q <= final_byte;
      done_q <= final_byte && job_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;
  assign stream_done_o = done_q;

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> last_q)
    else $error("stream_done without last_of_run");

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q < len)
    else $error("byte index beyond job length");

  a_idx_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 3'd0 |-> job_valid_i)
    else $error("job left queue while partly sent");

  a_pop_resets_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && job_ready_o |=> idx_q == 3'd0)
    else $error("index not cleared after job done");
`endif

endmodule

`default_nettype wire

// ===== sv/utf8_to_modified_utf8_top.sv =====
// Standard UTF-8 to modified UTF-8 converter, top level.
//
// Usage:
//   in_i  : one UTF-8 byte per word (in_byte), end_of_data on the final byte of a buffer.
//   out_o : one modified UTF-8 byte per word; last_of_run marks the final byte that an
//           input byte causes, stream_done the final byte of the buffer.
//   A 0x00 at a sequence start leaves as C0 80; a four-byte sequence leaves as two
//   three-byte surrogates on its fourth byte; all else is copied. A four-byte
//   sequence cut short by end_of_data is flushed raw.
// Timing:
//   The front end classifies a byte in the cycle it is accepted and pushes a job into a
//   two-entry queue; the back end expands jobs into bytes at one word per cycle through
//   an output register; output bytes pass a queue entry and then that register.
//   Input is taken every cycle while the queue has room, so plain bytes flow at one
//   per cycle; a null yields two output bytes and a four-byte sequence six, which the
//   single output port sets as the bound.
// Reset: clears sequence state, queue and output valid; no words are pending.
// Stall: a held-off output keeps its word; the queue fills and then in_i.ready drops.
`default_nettype none

module utf8_to_modified_utf8_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  u8m_in_if.sink     in_i,
  u8m_out_if.source  out_o
);
  import u8m_pkg::*;

  logic job_valid, job_ready;
  job_t job;
  logic q_valid, q_ready;
  job_t q_job;

  u8m_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_byte_i     (in_i.in_byte),
    .end_of_data_i (in_i.end_of_data),
    .job_valid_o   (job_valid),
    .job_o         (job),
    .job_ready_i   (job_ready)
  );

  u8m_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_job_i   (job),
    .push_ready_o (job_ready),
    .pop_valid_o  (q_valid),
    .pop_job_o    (q_job),
    .pop_ready_i  (q_ready)
  );

  u8m_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (q_job),
    .job_ready_o   (q_ready),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .last_of_run_o (out_o.last_of_run),
    .stream_done_o (out_o.stream_done)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the UTF-8 to modified UTF-8 converter.
`timescale 1ns / 1ps

module testbench;
  import u8m_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_OFF    = 150;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } mutf8_word_t;

  logic clk;
  logic rst_n;

  u8m_in_if  in_if ();
  u8m_out_if out_if ();

  utf8_to_modified_utf8_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Converter state as predicted from the accepted input words
  phase_e      seq_phase;
  logic [1:0]  copy_left;
  logic [1:0]  held_cnt;
  logic [7:0]  held_bytes [3];
  mutf8_word_t expected_words [$];

  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned words_checked;
  int unsigned surrogate_pairs;
  int unsigned raw_flushes;
  int unsigned hold_request;
  int unsigned long_holds;
  bit          idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Three-byte encoding of one UTF-16 surrogate unit
  function automatic logic [23:0] unit_bytes(input logic [15:0] unit);
    return {4'hE, unit[15:12], 2'b10, unit[11:6], 2'b10, unit[5:0]};
  endfunction

  function automatic void predict_words(input logic [7:0] c, input logic eod);
    logic [7:0]  run [$];
    logic [20:0] code_point;
    logic [19:0] offset;
    logic [23:0] hi_bytes;
    logic [23:0] lo_bytes;
    mutf8_word_t w;
    case (seq_phase)
      PH_COPY: begin
        run.push_back(c);
        if (copy_left != 2'd0) copy_left = copy_left - 2'd1;
        if (copy_left == 2'd0) seq_phase = PH_START;
      end
      PH_COLLECT: begin
        if (held_cnt == 2'd3) begin
          code_point = {held_bytes[0][2:0], held_bytes[1][5:0], held_bytes[2][5:0], c[5:0]};
          offset     = 20'(code_point - 21'h10000);
          hi_bytes   = unit_bytes(16'hD800 + 16'(offset[19:10]));
          lo_bytes   = unit_bytes(16'hDC00 + 16'(offset[9:0]));
          run = {hi_bytes[23:16], hi_bytes[15:8], hi_bytes[7:0],
                 lo_bytes[23:16], lo_bytes[15:8], lo_bytes[7:0]};
          surrogate_pairs++;
          held_cnt  = 2'd0;
          seq_phase = PH_START;
        end else begin
          held_bytes[held_cnt] = c;
          held_cnt = held_cnt + 2'd1;
        end
      end
      default: begin
        seq_phase = PH_START;
        if (c == NUL_BYTE) begin
          run = {NUL_ENC_HI, NUL_ENC_LO};
        end else if ((c & LEAD4_MASK) == LEAD4_VAL) begin
          held_bytes[0] = c;
          held_cnt  = 2'd1;
          seq_phase = PH_COLLECT;
        end else if ((c & LEAD2_MASK) == LEAD2_VAL) begin
          run.push_back(c);
          copy_left = 2'd1;
          seq_phase = PH_COPY;
        end else if ((c & LEAD3_MASK) == LEAD3_VAL) begin
          run.push_back(c);
          copy_left = 2'd2;
          seq_phase = PH_COPY;
        end else begin
          run.push_back(c);
        end
      end
    endcase
    if (eod) begin
      // a four-byte sequence cut short leaves raw, oldest byte first
      if (seq_phase == PH_COLLECT) begin
        for (int i = 0; i < int'(held_cnt); i++) run.push_back(held_bytes[i]);
        raw_flushes++;
      end
      seq_phase = PH_START;
      copy_left = 2'd0;
      held_cnt  = 2'd0;
    end
    foreach (run[i]) begin
      w.out_byte    = run[i];
      w.last_of_run = (i == run.size() - 1);
      w.stream_done = (i == run.size() - 1) && eod;
      expected_words.push_back(w);
    end
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eod);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.in_byte     <= b;
    in_if.end_of_data <= eod;
    do @(posedge clk); while (!in_if.ready);
    predict_words(b, eod);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed sequences with random content, some noise and cut-off ones
  task automatic send_random_sequence();
    int         pick;
    int         len;
    logic [7:0] seq [4];
    pick = $urandom_range(0, 99);
    len  = 1;
    seq[0] = 8'($urandom_range(1, 127));
    for (int i = 1; i < 4; i++) seq[i] = 8'($urandom_range(8'h80, 8'hBF));
    if (pick < 10) begin
      seq[0] = NUL_BYTE;
    end else if (pick < 25) begin
      seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
      len = 2;
    end else if (pick < 40) begin
      seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
      len = 3;
    end else if (pick < 70) begin
      seq[0] = 8'($urandom_range(8'hF0, 8'hF7));
      len = 4;
    end else if (pick < 85) begin
      len = 1;
    end else if (pick < 93) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) seq[i] = 8'($urandom_range(0, 255));
    end else begin
      seq[0] = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'hF0, 8'hF7))
                                           : 8'($urandom_range(8'hE0, 8'hEF));
      len = $urandom_range(1, 2);
    end
    for (int i = 0; i < len; i++) send_word(seq[i], $urandom_range(0, 19) == 0);
  endtask

  task automatic test_plain_and_null();
    send_word(8'h00, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);  // stray continuation
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_copied_sequences();
    send_word(8'hC2, 1'b0);
    send_word(8'h00, 1'b0);  // null inside a sequence is copied raw
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b0);
    send_word(8'hAC, 1'b0);
  endtask

  task automatic test_surrogates();
    // code point zero: offset wraps around 2^20
    send_word(8'hF0, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hF7, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b0);
  endtask

  task automatic test_truncation();
    send_word(8'hF4, 1'b1);
    send_word(8'hF0, 1'b0);
    send_word(8'h9F, 1'b1);
    send_word(8'hF0, 1'b0);
    send_word(8'h9F, 1'b0);
    send_word(8'h98, 1'b1);
    send_word(8'hE2, 1'b1);  // next byte starts a fresh buffer
  endtask

  task automatic test_backpressure();
    idle_on      = 1'b0;
    hold_request = HOLD_OFF;
    for (int i = 0; i < 12; i++) send_random_sequence();
  endtask

  task automatic test_random_traffic();
    int n;
    n = 0;
    while (bytes_sent < 390) begin
      if (n % 30 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_random_sequence();
      n++;
      if (n % 70 == 0) wait_drained();
    end
  endtask

  task automatic test_calm_tail();
    idle_on = 1'b0;
    while (bytes_sent < 430) send_random_sequence();
  endtask

  // Output side: random stall bursts plus the long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
        long_holds++;
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    mutf8_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_byte %h", out_if.out_byte);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_if.out_byte);
          fail_count++;
        end
        if (out_if.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, out_if.last_of_run);
          fail_count++;
        end
        if (out_if.stream_done !== want.stream_done) begin
          $error("stream_done: expected %b, got %b", want.stream_done, out_if.stream_done);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with work pending but no word moving on either side
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && (expected_words.size() != 0 || in_if.valid) &&
          !(in_if.valid && in_if.ready) && !(out_if.valid && out_if.ready))
        stuck++;
      else
        stuck = 0;
    end
    $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    seq_phase         = PH_START;
    copy_left         = 2'd0;
    held_cnt          = 2'd0;
    held_bytes        = '{default: 8'h00};
    fail_count        = 0;
    bytes_sent        = 0;
    words_checked     = 0;
    surrogate_pairs   = 0;
    raw_flushes       = 0;
    hold_request      = 0;
    long_holds        = 0;
    idle_on           = 1'b1;
    in_if.valid       = 1'b0;
    in_if.in_byte     = 8'h00;
    in_if.end_of_data = 1'b0;
    rst_n             = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_and_null();
    test_copied_sequences();
    test_surrogates();
    test_truncation();
    wait_drained();
    test_backpressure();
    wait_drained();
    idle_on = 1'b1;
    test_random_traffic();
    test_calm_tail();
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d input bytes, checked %0d output words (%0d surrogate pairs,",
             bytes_sent, words_checked, surrogate_pairs);
    $display("  %0d raw flushes, %0d long output hold-offs)", raw_flushes, long_holds);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
